/* rtl/pcm_frame_downmix_macros.svh */
// ----------------------------------------------------------------------------
// pcm_frame_downmix_macros.svh
// Assertion macros shared by the downmix RTL. Each expands to one labeled
// concurrent assertion clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PCM_FRAME_DOWNMIX_MACROS_SVH
`define PCM_FRAME_DOWNMIX_MACROS_SVH

// Same-cycle implication.
`define PFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pfd_pkg.sv */
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants of the PCM frame downmix block.
// ----------------------------------------------------------------------------
package pfd_pkg;

  // Default channel limit and sample queue depth.
  localparam int MAX_CHANNELS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Raw sample and result widths.
  localparam int SAMPLE_W = 64;
  localparam int Q31_W    = 32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FORMAT   = 2'd0,
    REG_BITS     = 2'd1,
    REG_CHANNELS = 2'd2
  } reg_index_t;

  // Sample format codes.
  localparam logic FMT_INT   = 1'b0;
  localparam logic FMT_FLOAT = 1'b1;

  // Decode class of one assembled sample.
  typedef enum logic [2:0] {
    KIND_ZERO = 3'd0,
    KIND_U8   = 3'd1,
    KIND_S16  = 3'd2,
    KIND_S24  = 3'd3,
    KIND_S32  = 3'd4,
    KIND_F32  = 3'd5,
    KIND_F64  = 3'd6
  } kind_t;

  // One complete channel sample as it travels from front to back.
  typedef struct packed {
    logic [SAMPLE_W-1:0] raw;
    kind_t               kind;
    logic                last;
  } sample_t;

endpackage

/* rtl/pfd_front.sv */
// ----------------------------------------------------------------------------
// pfd_front
// Configuration registers, byte assembly and sample classification. Emits one
// queue entry per completed channel sample, flagged at the end of a frame.
// ----------------------------------------------------------------------------
module pfd_front #(
  parameter int MAX_CHANNELS = pfd_pkg::MAX_CHANNELS_DEF,
  parameter int CH_W         = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [6:0]                cfg_data,
  input  logic                      take,
  input  logic [7:0]                data_byte,
  output logic                      push,
  output pfd_pkg::sample_t          push_sample,
  output logic [CH_W-1:0]           push_chans
);

  localparam logic [6:0]      MAX_CH7   = 7'(MAX_CHANNELS);
  localparam logic [CH_W-1:0] MAX_CH    = CH_W'(MAX_CHANNELS);
  localparam logic [3:0]      BPS_LIMIT = 4'd8;

  logic                      sample_format;
  logic [6:0]                bits_per_sample;
  logic [5:0]                channel_count;
  logic [pfd_pkg::SAMPLE_W-1:0] sample_bytes;
  logic [2:0]                byte_position;
  logic [CH_W-1:0]           channel_position;

  logic [3:0]                bps_raw;
  logic [3:0]                bps;
  logic [CH_W-1:0]           chans_eff;
  logic [pfd_pkg::SAMPLE_W-1:0] bytes_next;
  logic [3:0]                byte_count;
  logic                      sample_done;
  logic [CH_W-1:0]           chan_inc;
  logic                      frame_done;
  pfd_pkg::kind_t            kind;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format   <= pfd_pkg::FMT_INT;
      bits_per_sample <= 7'd16;
      channel_count   <= 6'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        pfd_pkg::REG_FORMAT:   sample_format   <= cfg_data[0];
        pfd_pkg::REG_BITS:     bits_per_sample <= cfg_data;
        pfd_pkg::REG_CHANNELS: channel_count   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Clamp bytes per sample to 1..8 and channels to 1..MAX_CHANNELS
  always_comb begin
    bps_raw = bits_per_sample[6:3];
    if (bps_raw == 4'd0) begin
      bps = 4'd1;
    end else if (bps_raw > BPS_LIMIT) begin
      bps = BPS_LIMIT;
    end else begin
      bps = bps_raw;
    end
    if (channel_count == 6'd0) begin
      chans_eff = CH_W'(1);
    end else if ({1'b0, channel_count} > MAX_CH7) begin
      chans_eff = MAX_CH;
    end else begin
      chans_eff = CH_W'(channel_count);
    end
  end

  // Merge the incoming byte and detect sample and frame ends
  always_comb begin
    bytes_next  = sample_bytes |
                  (pfd_pkg::SAMPLE_W'(data_byte) << {byte_position, 3'b000});
    byte_count  = {1'b0, byte_position} + 4'd1;
    sample_done = (byte_count >= bps);
    chan_inc    = channel_position + CH_W'(1);
    frame_done  = (chan_inc >= chans_eff);
  end

  // Classify the sample by format and depth
  always_comb begin
    kind = pfd_pkg::KIND_ZERO;
    if (sample_format == pfd_pkg::FMT_FLOAT) begin
      case (bits_per_sample)
        7'd32:   kind = pfd_pkg::KIND_F32;
        7'd64:   kind = pfd_pkg::KIND_F64;
        default: kind = pfd_pkg::KIND_ZERO;
      endcase
    end else begin
      case (bits_per_sample)
        7'd8:    kind = pfd_pkg::KIND_U8;
        7'd16:   kind = pfd_pkg::KIND_S16;
        7'd24:   kind = pfd_pkg::KIND_S24;
        7'd32:   kind = pfd_pkg::KIND_S32;
        default: kind = pfd_pkg::KIND_ZERO;
      endcase
    end
  end

  // Advance byte and channel positions
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_bytes     <= '0;
      byte_position    <= '0;
      channel_position <= '0;
    end else if (take) begin
      if (sample_done) begin
        sample_bytes     <= '0;
        byte_position    <= '0;
        channel_position <= frame_done ? '0 : chan_inc;
      end else begin
        sample_bytes     <= bytes_next;
        byte_position    <= byte_position + 3'd1;
      end
    end
  end

  assign push             = take && sample_done;
  assign push_sample.raw  = bytes_next;
  assign push_sample.kind = kind;
  assign push_sample.last = frame_done;
  assign push_chans       = chans_eff;

endmodule

/* rtl/pfd_queue.sv */
// ----------------------------------------------------------------------------
// pfd_queue
// Short register FIFO between front and back.
// ----------------------------------------------------------------------------
`include "pcm_frame_downmix_macros.svh"

module pfd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign full     = (count == CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];

  `PFD_ASSERT_NOW(a_no_underflow, pop, count != '0, "pfd_queue: pop while empty")
  `PFD_ASSERT_NOW(a_no_overflow, push && !pop, count != CNT_FULL, "pfd_queue: push while full")

endmodule

/* rtl/pfd_back.sv */
// ----------------------------------------------------------------------------
// pfd_back
// Sample decode to Q1.31, frame accumulation, mean by iterative division and
// the output register.
// ----------------------------------------------------------------------------
`include "pcm_frame_downmix_macros.svh"

module pfd_back #(
  parameter int MAX_CHANNELS = pfd_pkg::MAX_CHANNELS_DEF,
  parameter int CH_W         = $clog2(MAX_CHANNELS + 1),
  parameter int SUM_W        = pfd_pkg::Q31_W + $clog2(MAX_CHANNELS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  pfd_pkg::sample_t        q_sample,
  input  logic [CH_W-1:0]         q_chans,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [31:0]      mono_sample
);

  // Quotient bits resolved per divider cycle
  localparam int DIV_STEP = 8;
  localparam int DIV_CYC  = (SUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W    = DIV_CYC * DIV_STEP;
  localparam int CNT_W    = $clog2(DIV_CYC);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYC - 1);

  // Float field limits
  localparam logic [7:0]  F32_EXP_MAX   = 8'hFF;
  localparam logic [7:0]  F32_EXP_SAT   = 8'd127;
  localparam logic [7:0]  F32_EXP_ALIGN = 8'd119;
  localparam logic [10:0] F64_EXP_MAX   = 11'h7FF;
  localparam logic [10:0] F64_EXP_SAT   = 11'd1023;
  localparam logic [10:0] F64_EXP_ALIGN = 11'd1044;
  localparam logic [31:0] Q31_POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] Q31_NEG_MAX   = 32'h8000_0000;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  // Scale one raw sample to Q1.31
  function automatic logic signed [31:0] decode_q31(input pfd_pkg::sample_t s);
    logic [7:0]  e32;
    logic [23:0] m32;
    logic [10:0] e64;
    logic [52:0] m64;
    logic [52:0] sh64;
    logic [31:0] mag;
    logic        neg;
    logic [31:0] res;
    e32  = s.raw[30:23];
    m32  = {1'b1, s.raw[22:0]};
    e64  = s.raw[62:52];
    m64  = {1'b1, s.raw[51:0]};
    sh64 = m64 >> (F64_EXP_ALIGN - e64);
    mag  = '0;
    neg  = 1'b0;
    res  = '0;
    unique case (s.kind)
      pfd_pkg::KIND_U8:  res = {~s.raw[7], s.raw[6:0], 24'h0};
      pfd_pkg::KIND_S16: res = {s.raw[15:0], 16'h0};
      pfd_pkg::KIND_S24: res = {s.raw[23:0], 8'h0};
      pfd_pkg::KIND_S32: res = s.raw[31:0];
      pfd_pkg::KIND_F32: begin
        neg = s.raw[31];
        if (e32 == F32_EXP_MAX) begin
          res = (s.raw[22:0] != '0) ? '0 : (neg ? Q31_NEG_MAX : Q31_POS_MAX);
        end else if (e32 == '0) begin
          res = '0;
        end else if (e32 >= F32_EXP_SAT) begin
          res = neg ? Q31_NEG_MAX : Q31_POS_MAX;
        end else begin
          if (e32 >= F32_EXP_ALIGN) begin
            mag = 32'(m32) << (e32 - F32_EXP_ALIGN);
          end else begin
            mag = 32'(m32) >> (F32_EXP_ALIGN - e32);
          end
          res = neg ? -mag : mag;
        end
      end
      pfd_pkg::KIND_F64: begin
        neg = s.raw[63];
        if (e64 == F64_EXP_MAX) begin
          res = (s.raw[51:0] != '0) ? '0 : (neg ? Q31_NEG_MAX : Q31_POS_MAX);
        end else if (e64 == '0) begin
          res = '0;
        end else if (e64 >= F64_EXP_SAT) begin
          res = neg ? Q31_NEG_MAX : Q31_POS_MAX;
        end else begin
          mag = sh64[31:0];
          res = neg ? -mag : mag;
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  logic                    d_valid;
  logic signed [31:0]      d_value;
  logic                    d_last;
  logic [CH_W-1:0]         d_chans;
  logic                    d_hold;
  logic                    d_fire;
  logic                    div_start;

  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] acc_sum;
  logic [SUM_W-1:0]        acc_mag;

  div_state_t              div_state;
  logic                    div_neg;
  logic [CH_W-1:0]         div_divisor;
  logic [CH_W-1:0]         div_rem;
  logic [PAD_W-1:0]        div_work;
  logic [CNT_W-1:0]        div_cnt;
  logic [CH_W-1:0]         rem_next;
  logic [PAD_W-1:0]        work_next;
  logic [DIV_STEP-1:0]     q_bits;
  logic [CH_W:0]           trial;
  logic [31:0]             quot;
  logic [31:0]             result;
  logic                    out_free;

  // Hold a frame-end sample while the divider is still busy
  assign d_hold    = d_valid && d_last && (div_state != DIV_IDLE);
  assign d_fire    = d_valid && !d_hold;
  assign div_start = d_fire && d_last;
  assign q_pop     = q_valid && !d_hold;

  // Decode stage
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (!d_hold) begin
      d_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!d_hold) begin
      d_value <= decode_q31(q_sample);
      d_last  <= q_sample.last;
      d_chans <= q_chans;
    end
  end

  // Accumulate; clear at each frame end
  always_comb begin
    acc_sum = acc + SUM_W'(d_value);
    acc_mag = acc_sum[SUM_W-1] ? -acc_sum : acc_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (d_fire) begin
      acc <= d_last ? '0 : acc_sum;
    end
  end

  // Resolve DIV_STEP quotient bits against the narrow remainder
  always_comb begin
    rem_next = div_rem;
    q_bits   = '0;
    trial    = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {rem_next, div_work[PAD_W-1-i]};
      if (trial >= {1'b0, div_divisor}) begin
        rem_next             = CH_W'(trial - {1'b0, div_divisor});
        q_bits[DIV_STEP-1-i] = 1'b1;
      end else begin
        rem_next = trial[CH_W-1:0];
      end
    end
    work_next = {div_work[PAD_W-DIV_STEP-1:0], q_bits};
    quot      = div_work[31:0];
    result    = div_neg ? -quot : quot;
  end

  assign out_free = !out_valid || !out_stall;

  // Divider sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      div_state <= DIV_IDLE;
      div_cnt   <= '0;
    end else begin
      unique case (div_state)
        DIV_IDLE: begin
          if (div_start) begin
            div_state <= DIV_RUN;
            div_cnt   <= '0;
          end
        end
        DIV_RUN: begin
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_LAST) begin
            div_state <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          if (out_free) begin
            div_state <= DIV_IDLE;
          end
        end
        default: div_state <= DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_neg     <= acc_sum[SUM_W-1];
      div_divisor <= d_chans;
      div_rem     <= '0;
      div_work    <= PAD_W'(acc_mag);
    end else if (div_state == DIV_RUN) begin
      div_rem  <= rem_next;
      div_work <= work_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((div_state == DIV_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((div_state == DIV_DONE) && out_free) begin
      mono_sample <= result;
    end
  end

  `PFD_ASSERT_NOW(a_start_idle, div_start, div_state == DIV_IDLE, "pfd_back: divider restarted while busy")
  `PFD_ASSERT_NEXT(a_acc_clear, div_start, acc == '0, "pfd_back: sum not cleared at frame end")
  `PFD_ASSERT_NEXT(a_out_source, !out_valid && (div_state != DIV_DONE), !out_valid, "pfd_back: result without division")

endmodule

/* rtl/pcm_frame_downmix.sv */
// ----------------------------------------------------------------------------
// pcm_frame_downmix
// Multichannel PCM byte stream to mono Q1.31 frame mean.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall / data_byte carries interleaved
//   little-endian sample bytes, one per transaction. in_stall rises only when
//   the sample queue between front and back is full.
//   Output channel: out_valid / out_stall / mono_sample carries one signed
//   Q1.31 frame mean per completed frame. A stalled result holds in the output
//   register; the front keeps taking bytes until the queue fills.
//   Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data writes format,
//   bits per sample and channel count; cfg_ready is always high. Write only
//   while no frame result is pending.
//   Throughput: one byte per cycle while in_stall is low. Each frame end holds
//   the divider through its run and done states (37-bit sum at 32 channels,
//   8 quotient bits per cycle); frame ends that arrive while it is busy wait
//   in the queue, which fills and stalls the input.
//   Reset (rst, synchronous): restores default configuration (integer PCM,
//   16 bits, one channel), clears positions, queue, sum and output.
// ----------------------------------------------------------------------------
module pcm_frame_downmix #(
  parameter int MAX_CHANNELS = pfd_pkg::MAX_CHANNELS_DEF,
  parameter int QUEUE_DEPTH  = pfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] mono_sample
);

  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W = pfd_pkg::Q31_W + $clog2(MAX_CHANNELS);
  localparam int ENT_W = $bits(pfd_pkg::sample_t) + CH_W;

  logic                 take;
  logic                 push;
  pfd_pkg::sample_t     push_sample;
  logic [CH_W-1:0]      push_chans;
  logic                 q_full;
  logic                 q_valid;
  logic [ENT_W-1:0]     q_data;
  logic                 q_pop;
  pfd_pkg::sample_t     q_sample;
  logic [CH_W-1:0]      q_chans;

  // Accept bytes whenever the queue has room
  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign take      = in_valid && !in_stall;

  pfd_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CH_W         (CH_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .take        (take),
    .data_byte   (data_byte),
    .push        (push),
    .push_sample (push_sample),
    .push_chans  (push_chans)
  );

  pfd_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sample, push_chans}),
    .pop       (q_pop),
    .full      (q_full),
    .rd_valid  (q_valid),
    .rd_data   (q_data)
  );

  // Split the queue entry back into sample and channel count
  assign q_sample = q_data[ENT_W-1:CH_W];
  assign q_chans  = q_data[CH_W-1:0];

  pfd_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CH_W         (CH_W),
    .SUM_W        (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_sample    (q_sample),
    .q_chans     (q_chans),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mono_sample (mono_sample)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCM frame downmix. A clocked driver feeds data
// bytes from a queue, in bursts with random gaps. A bit-accurate predictor
// tracks sample assembly, Q1.31 scaling and the frame mean. A monitor compares
// every output transaction with the oldest predicted mean. Configuration
// changes only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb;

  localparam int SETTLE_CYC   = 32;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_BYTES = 1400;
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int MAX_CH       = 32;
  // Index with no register behind it; writes there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [6:0]         cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] mono_sample;

  pcm_frame_downmix DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mono_sample (mono_sample)
  );

  // Predictor copy of the configuration and the assembly state
  logic        fmt_sel      = pfd_pkg::FMT_INT;
  logic [6:0]  depth_bits   = 7'd16;
  logic [5:0]  chan_setting = 6'd1;
  logic [63:0] acc_bytes    = '0;
  int          acc_byte_idx = 0;
  int          acc_chan_idx = 0;
  longint      frame_sum    = 0;

  logic signed [31:0] mono_expected[$];
  logic [7:0]         pending_bytes[$];

  int mismatches  = 0;
  int gap_max     = 0;
  int stall_pct   = 0;
  bit sender_hold   = 1'b0;
  bit long_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint clamp_q31(logic [63:0] mag, bit neg, bit over);
    if (over || mag > 64'h7FFF_FFFF) begin
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // Truncate float32 times 2^31 toward zero; NaN and subnormals give zero
  function automatic longint f32_to_q31(logic [31:0] w);
    int          e;
    int          k;
    logic [63:0] m;
    logic [63:0] mag;
    e = w[30:23];
    m = {40'b0, 1'b1, w[22:0]};
    if (e == 255) return (w[22:0] != 0) ? 0 : clamp_q31('0, w[31], 1'b1);
    if (e == 0) return 0;
    k = e - 119;
    if (k >= 8) return clamp_q31('0, w[31], 1'b1);
    if (k >= 0) mag = m << k;
    else if (-k >= 32) mag = '0;
    else mag = m >> (-k);
    return clamp_q31(mag, w[31], 1'b0);
  endfunction

  function automatic longint f64_to_q31(logic [63:0] w);
    int          e;
    int          k;
    logic [63:0] m;
    logic [63:0] mag;
    e = w[62:52];
    m = {11'b0, 1'b1, w[51:0]};
    if (e == 2047) return (w[51:0] != 0) ? 0 : clamp_q31('0, w[63], 1'b1);
    if (e == 0) return 0;
    k = e - 1044;
    if (k >= -21) return clamp_q31('0, w[63], 1'b1);
    if (-k >= 64) mag = '0;
    else mag = m >> (-k);
    return clamp_q31(mag, w[63], 1'b0);
  endfunction

  // Scale one assembled channel sample to Q1.31 under the current format
  function automatic longint channel_q31(logic [63:0] x);
    if (fmt_sel == pfd_pkg::FMT_FLOAT) begin
      if (depth_bits == 7'd32) return f32_to_q31(x[31:0]);
      if (depth_bits == 7'd64) return f64_to_q31(x);
      return 0;
    end
    case (depth_bits)
      7'd8:    return (longint'(x[7:0]) - 128) * 16777216;
      7'd16:   return longint'($signed(x[15:0])) * 65536;
      7'd24:   return longint'($signed(x[23:0])) * 256;
      7'd32:   return longint'($signed(x[31:0]));
      default: return 0;
    endcase
  endfunction

  // Advance the predictor by one accepted byte; queue a mean on frame end
  function automatic void absorb_byte(logic [7:0] b);
    int     bps;
    int     chans;
    longint mean;
    bps = depth_bits / 8;
    if (bps == 0) bps = 1;
    if (bps > 8) bps = 8;
    chans = chan_setting;
    if (chans == 0) chans = 1;
    if (chans > MAX_CH) chans = MAX_CH;
    acc_bytes = acc_bytes | (64'(b) << (8 * (acc_byte_idx % 8)));
    if (acc_byte_idx + 1 < bps) begin
      acc_byte_idx++;
      return;
    end
    frame_sum += channel_q31(acc_bytes);
    acc_bytes = '0;
    acc_byte_idx = 0;
    acc_chan_idx++;
    if (acc_chan_idx < chans) return;
    mean = frame_sum / chans;
    mono_expected.insert(mono_expected.size(), mean[31:0]);
    frame_sum = 0;
    acc_chan_idx = 0;
  endfunction

  // Sample value biased toward extremes and float special cases
  function automatic logic [63:0] pick_value(logic f, logic [6:0] bits, int bps);
    int          r;
    logic [63:0] v;
    logic [63:0] top;
    r = $urandom_range(0, 9);
    v = {$urandom(), $urandom()};
    if (f == pfd_pkg::FMT_FLOAT && bits == 7'd32) begin
      if (r < 6) v[30:23] = 8'($urandom_range(96, 134));
      else if (r == 6) v[30:23] = 8'h00;
      else if (r == 7) v[30:23] = 8'hFF;
      else if (r == 8) v[30:23] = 8'd127;
      if ($urandom_range(0, 3) == 0) v[22:0] = '0;
    end else if (f == pfd_pkg::FMT_FLOAT && bits == 7'd64) begin
      if (r < 6) v[62:52] = 11'($urandom_range(1000, 1054));
      else if (r == 6) v[62:52] = 11'h000;
      else if (r == 7) v[62:52] = 11'h7FF;
      else if (r == 8) v[62:52] = 11'd1023;
      if ($urandom_range(0, 3) == 0) v[51:0] = '0;
    end else begin
      top = 64'd1 << (8 * bps - 1);
      if (r == 0) v = '0;
      else if (r == 1) v = '1;
      else if (r == 2) v = top;
      else if (r == 3) v = top - 1;
    end
    return v;
  endfunction

  task automatic push_sample(int nbytes, logic [63:0] v);
    for (int i = 0; i < nbytes; i++) begin
      pending_bytes.insert(pending_bytes.size(), v[8 * i +: 8]);
    end
  endtask

  // Write one register and mirror it into the predictor
  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pfd_pkg::REG_FORMAT:   fmt_sel = val[0];
      pfd_pkg::REG_BITS:     depth_bits = val;
      pfd_pkg::REG_CHANNELS: chan_setting = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic f, logic [6:0] bits, logic [6:0] chans);
    write_reg(pfd_pkg::REG_FORMAT, {6'b0, f});
    write_reg(pfd_pkg::REG_BITS, bits);
    write_reg(pfd_pkg::REG_CHANNELS, chans);
    @(negedge clk);
  endtask

  // Wait for all bytes sent and all means back, then let the pipeline settle
  task automatic drain_block();
    while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
    while (mono_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Send bytes in bursts; hold the payload while stalled
  always @(posedge clk) begin : byte_driver
    int burst_left;
    int gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) absorb_byte(data_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0 && !sender_hold) begin
          data_byte <= pending_bytes.pop_front();
          in_valid  <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if (gap_max > 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(1, gap_max);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the output at random, or hold off for a long stretch on request
  always @(posedge clk) begin : mean_receiver
    int hold_left;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Check each output transaction against the oldest predicted mean
  always @(posedge clk) begin : mean_monitor
    logic signed [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (mono_expected.size() == 0) begin
        $display("%0t: unexpected mono_sample, expected none, actual %0d",
                 $time, mono_sample);
        mismatches++;
      end else begin
        want = mono_expected.pop_front();
        if (mono_sample !== want) begin
          $display("%0t: mono_sample mismatch, expected %0d, actual %0d",
                   $time, want, mono_sample);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int          p;
    int          r;
    int          bps;
    int          chans;
    int          nframes;
    int          nbytes;
    int          cut;
    int          random_fed;
    logic [6:0]  fdata;
    logic [6:0]  bdata;
    logic [6:0]  cdata;
    random_fed = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults, 16-bit mono: full-scale negative and positive
    push_sample(2, 64'h8000);
    push_sample(2, 64'h7FFF);
    drain_block();
    // Unsigned 8-bit extremes
    set_config(pfd_pkg::FMT_INT, 7'd8, 7'd1);
    push_sample(1, 64'h00);
    push_sample(1, 64'hFF);
    drain_block();
    // 32-bit stereo with an odd sum: mean truncates toward zero
    set_config(pfd_pkg::FMT_INT, 7'd32, 7'd2);
    push_sample(4, 64'h8000_0000);
    push_sample(4, 64'hFFFF_FFFF);
    drain_block();
    // Float32 NaN and negative infinity
    set_config(pfd_pkg::FMT_FLOAT, 7'd32, 7'd1);
    push_sample(4, 64'h7FC0_0000);
    push_sample(4, 64'hFF80_0000);
    drain_block();
    // Depth below eight bits and zero channels
    set_config(pfd_pkg::FMT_INT, 7'd0, 7'd0);
    push_sample(1, 64'h5A);
    drain_block();

    // Fill the block behind a long receiver hold-off
    set_config(pfd_pkg::FMT_INT, 7'd8, 7'd1);
    long_hold_req = 1'b1;
    for (int i = 0; i < 160; i++) push_sample(1, {$urandom(), $urandom()});
    random_fed += 160;
    drain_block();

    // Random phases, each under its own configuration and idling mix
    p = 0;
    while (random_fed < RANDOM_BYTES) begin
      gap_max = (p % 4 == 3) ? 0 : $urandom_range(0, 8);
      stall_pct = (p % 4 == 3) ? 0 : $urandom_range(0, 70);
      fdata = 7'($urandom_range(0, 127));
      r = $urandom_range(0, 9);
      if (r >= 8) bdata = 7'($urandom_range(0, 127));
      else if (fdata[0] == pfd_pkg::FMT_FLOAT) bdata = (r < 4) ? 7'd32 : 7'd64;
      else bdata = 7'(8 * (r % 4 + 1));
      r = $urandom_range(0, 9);
      if (r < 6) cdata = 7'($urandom_range(1, 4));
      else if (r < 8) cdata = 7'($urandom_range(5, 32));
      else if (r == 8) cdata = 7'($urandom_range(0, 127));
      else cdata = 7'd32;
      if (p == 0) begin
        fdata = '1;
        bdata = '1;
        cdata = '1;
      end else if (p == 1) begin
        fdata = '0;
        bdata = '0;
        cdata = '0;
      end
      // Skip a write now and then so a register keeps its old value
      if (p < 3 || $urandom_range(0, 5) != 0) write_reg(pfd_pkg::REG_FORMAT, fdata);
      if (p < 3 || $urandom_range(0, 5) != 0) write_reg(pfd_pkg::REG_BITS, bdata);
      if (p < 3 || $urandom_range(0, 5) != 0) write_reg(pfd_pkg::REG_CHANNELS, cdata);
      if (p == 2) write_reg(REG_SPARE, 7'($urandom_range(0, 127)));
      @(negedge clk);

      bps = depth_bits / 8;
      if (bps == 0) bps = 1;
      if (bps > 8) bps = 8;
      chans = chan_setting;
      if (chans == 0) chans = 1;
      if (chans > MAX_CH) chans = MAX_CH;
      nframes = $urandom_range(30, 120) / (bps * chans);
      if (nframes == 0) nframes = 1;
      for (int f = 0; f < nframes; f++) begin
        for (int c = 0; c < chans; c++) begin
          push_sample(bps, pick_value(fmt_sel, depth_bits, bps));
        end
      end
      // Leave a frame unfinished now and then, across the next write
      cut = 0;
      if (bps * chans > 1 && $urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, bps * chans - 1);
        push_sample(cut, {$urandom(), $urandom()});
      end
      nbytes = nframes * bps * chans + cut;
      random_fed += nbytes;

      // Pause the sender mid-phase until every pending mean has come back
      if (p % 5 == 2) begin
        while (pending_bytes.size() > nbytes / 2) @(negedge clk);
        sender_hold = 1'b1;
        while (in_valid || mono_expected.size() != 0) @(negedge clk);
        sender_hold = 1'b0;
      end
      drain_block();
      p++;
    end

    if (mismatches == 0 && mono_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/pfd_pkg.sv
rtl/pfd_front.sv
rtl/pfd_queue.sv
rtl/pfd_back.sv
rtl/pcm_frame_downmix.sv
tb/tb.sv
